// ===== sv/bdqs_pkg.sv =====
// Shared types and constants for the bounded deque with search.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bdqs_pkg;

  // Ring slots; must be a power of two so the slot pointers wrap naturally.
  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);

  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  // Entries in the queue between the front and back units.
  localparam int QDEPTH   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SEARCH     = 3'd4,
    CMD_REVERSE    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_SEARCH,
    OP_REVERSE,
    OP_NOP
  } op_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Decoded command; at_front selects the logical front for push and pop.
  typedef struct packed {
    op_kind_t            kind;
    logic                at_front;
    logic [DATA_W-1:0]   value;
  } op_t;

  typedef struct packed {
    status_t             status;
    logic                found;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/bdqs_front.sv =====
// Front unit: accepts command beats and decodes them into queue operations.
// Depends on bdqs_pkg.
`default_nettype none

module bdqs_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic [bdqs_pkg::CMD_W-1:0]    command,
  input  logic signed [bdqs_pkg::DATA_W-1:0] value,
  output logic                          op_valid,
  output bdqs_pkg::op_t                 op,
  input  logic                          op_ready
);
  import bdqs_pkg::*;

  op_t  decoded;
  logic load;

  always_comb begin
    decoded.value    = value;
    decoded.at_front = 1'b0;
    decoded.kind     = OP_NOP;
    unique case (cmd_t'(command))
      CMD_PUSH_FRONT: begin
        decoded.kind     = OP_PUSH;
        decoded.at_front = 1'b1;
      end
      CMD_PUSH_BACK:  decoded.kind = OP_PUSH;
      CMD_POP_FRONT: begin
        decoded.kind     = OP_POP;
        decoded.at_front = 1'b1;
      end
      CMD_POP_BACK:   decoded.kind = OP_POP;
      CMD_SEARCH:     decoded.kind = OP_SEARCH;
      CMD_REVERSE:    decoded.kind = OP_REVERSE;
      default:        decoded.kind = OP_NOP;
    endcase
  end

  assign cmd_stall = op_valid && !op_ready;
  assign load      = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (load) begin
      op_valid <= 1'b1;
    end else if (op_ready) begin
      op_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op <= decoded;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bdqs_fifo.sv =====
// Short operation queue between the front and back units.
// Depends on bdqs_pkg (op_t, QDEPTH).
`default_nettype none

module bdqs_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  bdqs_pkg::op_t wr_data,
  output logic          rd_valid,
  input  logic          rd_take,
  output bdqs_pkg::op_t rd_data
);
  import bdqs_pkg::*;

  localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int FILL_W = $clog2(QDEPTH + 1);

  op_t              slots [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [FILL_W-1:0] fill;
  logic             push;
  logic             pop;

  assign wr_ready = fill != FILL_W'(QDEPTH);
  assign rd_valid = fill != '0;
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + FILL_W'(1);
        2'b01:   fill <= fill - FILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bdqs_back.sv =====
// Back unit: holds the ring of entries and carries out each queued operation.
// Search walks one entry per cycle unless results stall. Depends on bdqs_pkg.
`default_nettype none

module bdqs_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  output logic              op_take,
  input  bdqs_pkg::op_t     op,
  output logic              res_valid,
  input  logic              res_stall,
  output bdqs_pkg::result_t res
);
  import bdqs_pkg::*;

  logic [DATA_W-1:0] store [DEPTH];
  logic [IDX_W-1:0]  front_index, front_index_next;
  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic              reversed, reversed_next;

  logic              walking, walking_next;
  logic [CNT_W-1:0]  walk_pos, walk_pos_next;
  logic [DATA_W-1:0] key, key_next;
  logic              have_pend, have_pend_next;
  logic [IDX_W-1:0]  pend_pos, pend_pos_next;

  logic              res_load;
  result_t           res_next;

  logic              write_en;
  logic [IDX_W-1:0]  write_slot;

  logic              out_free;
  logic              full;
  logic              empty;
  logic              at_low;
  logic              walk_done;
  logic [CNT_W-1:0]  rev_off;
  logic [IDX_W-1:0]  slot;
  logic              hit;

  assign out_free  = !res_valid || !res_stall;
  assign full      = entry_count == CNT_W'(DEPTH);
  assign empty     = entry_count == '0;
  assign at_low    = op.at_front != reversed;
  assign walk_done = walk_pos == entry_count;
  assign rev_off   = entry_count - CNT_W'(1) - walk_pos;
  assign slot      = reversed ? front_index + rev_off[IDX_W-1:0]
                              : front_index + walk_pos[IDX_W-1:0];
  assign hit       = store[slot] == key;
  assign op_take   = op_valid && !walking && out_free;

  always_comb begin
    front_index_next = front_index;
    entry_count_next = entry_count;
    reversed_next    = reversed;
    walking_next     = walking;
    walk_pos_next    = walk_pos;
    key_next         = key;
    have_pend_next   = have_pend;
    pend_pos_next    = pend_pos;
    write_en         = 1'b0;
    write_slot       = front_index;
    res_load         = 1'b0;
    res_next.status   = ST_OK;
    res_next.found    = 1'b0;
    res_next.position = '0;
    res_next.count    = COUNT_W'(entry_count);
    res_next.last     = 1'b1;

    if (walking) begin
      if (walk_done) begin
        // Flush the held match as the final beat, or report no match.
        if (out_free) begin
          res_load          = 1'b1;
          res_next.found    = have_pend;
          res_next.position = have_pend ? POS_W'(pend_pos) : '0;
          walking_next      = 1'b0;
        end
      end else if (hit && have_pend) begin
        // A later match exists, so the held one is not last.
        if (out_free) begin
          res_load          = 1'b1;
          res_next.found    = 1'b1;
          res_next.position = POS_W'(pend_pos);
          res_next.last     = 1'b0;
          pend_pos_next     = walk_pos[IDX_W-1:0];
          walk_pos_next     = walk_pos + CNT_W'(1);
        end
      end else begin
        if (hit) begin
          have_pend_next = 1'b1;
          pend_pos_next  = walk_pos[IDX_W-1:0];
        end
        walk_pos_next = walk_pos + CNT_W'(1);
      end
    end else if (op_take) begin
      res_load = 1'b1;
      unique case (op.kind)
        OP_PUSH: begin
          if (full) begin
            res_next.status = ST_FULL;
          end else begin
            write_en = 1'b1;
            if (at_low) begin
              write_slot       = front_index - IDX_W'(1);
              front_index_next = front_index - IDX_W'(1);
            end else begin
              write_slot = front_index + entry_count[IDX_W-1:0];
            end
            entry_count_next = entry_count + CNT_W'(1);
            res_next.count   = COUNT_W'(entry_count + CNT_W'(1));
          end
        end
        OP_POP: begin
          if (empty) begin
            res_next.status = ST_EMPTY;
          end else begin
            if (at_low) begin
              front_index_next = front_index + IDX_W'(1);
            end
            entry_count_next = entry_count - CNT_W'(1);
            res_next.count   = COUNT_W'(entry_count - CNT_W'(1));
          end
        end
        OP_SEARCH: begin
          if (empty) begin
            res_next.status = ST_EMPTY;
          end else begin
            res_load       = 1'b0;
            walking_next   = 1'b1;
            walk_pos_next  = '0;
            key_next       = op.value;
            have_pend_next = 1'b0;
          end
        end
        OP_REVERSE: begin
          if (empty) begin
            res_next.status = ST_EMPTY;
          end else begin
            reversed_next = !reversed;
          end
        end
        default: begin
          res_next.status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      entry_count <= '0;
      reversed    <= 1'b0;
      walking     <= 1'b0;
      have_pend   <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      front_index <= front_index_next;
      entry_count <= entry_count_next;
      reversed    <= reversed_next;
      walking     <= walking_next;
      have_pend   <= have_pend_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    walk_pos <= walk_pos_next;
    key      <= key_next;
    pend_pos <= pend_pos_next;
    if (res_load) begin
      res <= res_next;
    end
    if (write_en) begin
      store[write_slot] <= op.value;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bounded_deque_with_search_unit.sv =====
// Bounded deque of signed 32-bit values with push/pop at either end, search
// and reverse. Each command beat yields one result beat, except a search with
// matches, which yields one beat per matching position, front to back, with
// last set on the final one. A command passes a decode register and a
// two-entry operation queue before the back unit executes it and registers
// its first result beat. Push, pop, reverse and unknown commands are each
// carried out in a single step of the back unit; a search occupies it while
// the single compare walks the ring one entry per cycle, pausing while a held
// match waits on a stalled output, and then emits the closing beat. The front
// keeps accepting commands while a search runs, until the decode register and
// the queue are full. Reverse only flips a direction flag. A full list drops
// the pushed value and reports full.
// Depends on bdqs_pkg, bdqs_front, bdqs_fifo, bdqs_back.
`default_nettype none

module bounded_deque_with_search_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  output logic                                 cmd_stall,
  input  logic [bdqs_pkg::CMD_W-1:0]           command,
  input  logic signed [bdqs_pkg::DATA_W-1:0]   value,
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output logic [bdqs_pkg::STATUS_W-1:0]        status,
  output logic                                 found,
  output logic [bdqs_pkg::POS_W-1:0]           position,
  output logic [bdqs_pkg::COUNT_W-1:0]         count,
  output logic                                 last
);
  import bdqs_pkg::*;

  logic    dec_valid;
  logic    dec_ready;
  op_t     dec_op;
  logic    q_valid;
  logic    q_take;
  op_t     q_op;
  result_t res;

  bdqs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .command   (command),
    .value     (value),
    .op_valid  (dec_valid),
    .op        (dec_op),
    .op_ready  (dec_ready)
  );

  bdqs_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (dec_valid),
    .wr_ready (dec_ready),
    .wr_data  (dec_op),
    .rd_valid (q_valid),
    .rd_take  (q_take),
    .rd_data  (q_op)
  );

  bdqs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (q_valid),
    .op_take   (q_take),
    .op        (q_op),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  assign status   = res.status;
  assign found    = res.found;
  assign position = res.position;
  assign count    = res.count;
  assign last     = res.last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> count <= COUNT_W'(DEPTH))
    else $error("result count above capacity");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && found |-> status == ST_OK)
    else $error("match beat with non-ok status");

  a_nomatch_pos: assert property (@(posedge clk) disable iff (rst)
    res_valid && !found |-> position == '0 && last)
    else $error("non-match beat with position or not last");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_FULL |-> count == COUNT_W'(DEPTH))
    else $error("full status while list not full");

endmodule

`default_nettype wire
